>>> design/hidkr_pkg.sv
package hidkr_pkg;

    localparam int DEFAULT_KEY_SLOTS = 6;
    localparam int REPORT_SLOTS      = 6;
    localparam int DROP_KEYS         = 5;
    localparam int TIMER_W           = 10;
    localparam int CFG_IDX_W         = 2;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECENT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP      = 2'd2;

    localparam logic [TIMER_W-1:0] RST_HOLD_TICKS   = 10'd1000;
    localparam logic [TIMER_W-1:0] RST_RECENT_LIMIT = 10'd990;
    localparam logic [TIMER_W-1:0] RST_MIN_GAP      = 10'd10;

    localparam logic [7:0] USAGE_CAPS     = 8'h39;
    localparam logic [7:0] USAGE_DOWN     = 8'h51;
    localparam logic [7:0] USAGE_APP      = 8'h65;
    localparam logic [7:0] USAGE_MUHENKAN = 8'h8B;
    localparam logic [7:0] USAGE_ENTER    = 8'h28;
    localparam logic [7:0] USAGE_LGUI     = 8'hE3;
    localparam logic [7:0] USAGE_MOD_BASE = 8'hE0;
    localparam logic [7:0] SHIFT_MASK     = 8'h22;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_modifiers;
        logic [7:0] slot_0;
        logic [7:0] slot_1;
        logic [7:0] slot_2;
        logic [7:0] slot_3;
        logic [7:0] slot_4;
        logic [7:0] slot_5;
    } out_report_t;

    typedef struct packed {
        logic [TIMER_W-1:0] hold_ticks;
        logic [TIMER_W-1:0] recent_limit;
        logic [TIMER_W-1:0] min_gap;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         mods;
        logic               caps_held;
        logic [TIMER_W-1:0] hold_timer;
        logic [TIMER_W-1:0] tap_timer;
        logic [7:0]         caps_sub;
        logic               enter_sub;
    } ctl_state_t;

    typedef struct packed {
        logic [DROP_KEYS-1:0]      drop_en;
        logic [DROP_KEYS-1:0][7:0] drop_key;
        logic                      push_en;
        logic [7:0]                lead_key;
    } edit_req_t;

    function automatic logic is_mod(input logic [7:0] k);
        return k[7:3] == USAGE_MOD_BASE[7:3];
    endfunction

    function automatic logic [7:0] mod_bit(input logic [7:0] k);
        return 8'(8'd1 << k[2:0]);
    endfunction

endpackage

>>> design/hidkr_slot_edit.sv
module hidkr_slot_edit
    import hidkr_pkg::*;
#(
    parameter int KEY_SLOTS = DEFAULT_KEY_SLOTS
)
(
    input  logic [KEY_SLOTS-1:0][7:0] slots,
    input  edit_req_t                 edit,
    output logic [KEY_SLOTS-1:0][7:0] slots_out
);

    localparam int POS_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [KEY_SLOTS-1:0]            keep;
    logic [KEY_SLOTS-1:0][POS_W-1:0] pos;
    logic [KEY_SLOTS-1:0][7:0]       comp;

    // drop matching keys
    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            keep[i] = 1'b1;
            for (int d = 0; d < DROP_KEYS; d++)
            begin
                if (edit.drop_en[d] && slots[i] == edit.drop_key[d])
                begin
                    keep[i] = 1'b0;
                end
            end
        end
    end

    // compact survivors towards the front
    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            pos[i] = POS_W'($countones(keep & KEY_SLOTS'((1 << i) - 1)));
        end
        for (int j = 0; j < KEY_SLOTS; j++)
        begin
            comp[j] = 8'h00;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                if (keep[i] && pos[i] == POS_W'(j))
                begin
                    comp[j] = comp[j] | slots[i];
                end
            end
        end
    end

    // push to the front, oldest falls off
    always_comb
    begin
        if (edit.push_en)
        begin
            slots_out[0] = edit.lead_key;
            for (int j = 1; j < KEY_SLOTS; j++)
            begin
                slots_out[j] = comp[j-1];
            end
        end
        else
        begin
            slots_out = comp;
        end
    end

endmodule

>>> design/hidkr_remap.sv
module hidkr_remap
    import hidkr_pkg::*;
(
    input  in_req_t    item,
    input  ctl_state_t st,
    input  cfg_t       cfg,
    output ctl_state_t st_next,
    output edit_req_t  edit,
    output logic       emit
);

    always_comb
    begin
        logic [7:0]         k;
        logic [TIMER_W-1:0] t;
        logic [7:0]         clr;
        logic               caps_plain;

        st_next    = st;
        edit       = '0;
        emit       = 1'b0;
        k          = item.key;
        t          = st.hold_timer;
        clr        = 8'h00;
        caps_plain = (item.key == USAGE_CAPS) && ((st.mods & SHIFT_MASK) == 8'h00);

        unique case (item.kind)
            KIND_PRESS:
            begin
                emit = 1'b1;
                if (caps_plain)
                begin
                    // double tap becomes left gui
                    if (st.tap_timer != '0)
                    begin
                        edit.drop_en[0]  = 1'b1;
                        edit.drop_key[0] = USAGE_CAPS;
                        k                = USAGE_LGUI;
                        st_next.caps_sub = USAGE_LGUI;
                    end
                    if (!st.caps_held && st.hold_timer < cfg.recent_limit)
                    begin
                        if (t != '0 && t < cfg.min_gap)
                        begin
                            t = cfg.min_gap;
                        end
                        st_next.tap_timer = t;
                    end
                    st_next.hold_timer = cfg.hold_ticks;
                end
                else
                begin
                    st_next.hold_timer = '0;
                    st_next.tap_timer  = '0;
                end

                if (k == USAGE_CAPS)
                begin
                    st_next.caps_held = 1'b1;
                end
                else if (st.caps_held && k == USAGE_DOWN)
                begin
                    k = USAGE_APP;
                end

                if (is_mod(k))
                begin
                    st_next.mods = st.mods | mod_bit(k);
                end
                else if (k == USAGE_MUHENKAN && st.mods == 8'h00)
                begin
                    st_next.enter_sub = 1'b1;
                    edit.drop_en[1]   = 1'b1;
                    edit.drop_key[1]  = USAGE_ENTER;
                    edit.push_en      = 1'b1;
                    edit.lead_key     = USAGE_ENTER;
                end
                else
                begin
                    if (st.enter_sub)
                    begin
                        edit.drop_en[2]   = 1'b1;
                        edit.drop_key[2]  = USAGE_ENTER;
                        edit.drop_en[3]   = 1'b1;
                        edit.drop_key[3]  = USAGE_MUHENKAN;
                        st_next.enter_sub = 1'b0;
                    end
                    if (k != 8'h00)
                    begin
                        edit.drop_en[4]  = 1'b1;
                        edit.drop_key[4] = k;
                        edit.push_en     = 1'b1;
                        edit.lead_key    = k;
                    end
                end
            end
            KIND_RELEASE:
            begin
                emit = 1'b1;
                if (item.key == USAGE_CAPS)
                begin
                    st_next.caps_held = 1'b0;
                    edit.drop_en[0]   = (st.caps_sub != 8'h00);
                    edit.drop_key[0]  = st.caps_sub;
                    if (is_mod(st.caps_sub))
                    begin
                        clr = clr | mod_bit(st.caps_sub);
                    end
                    st_next.caps_sub = 8'h00;
                end
                if (item.key == USAGE_CAPS || item.key == USAGE_DOWN)
                begin
                    edit.drop_en[1]  = 1'b1;
                    edit.drop_key[1] = USAGE_APP;
                end
                if (st.enter_sub)
                begin
                    edit.drop_en[2]  = 1'b1;
                    edit.drop_key[2] = USAGE_ENTER;
                    edit.drop_en[3]  = 1'b1;
                    edit.drop_key[3] = USAGE_MUHENKAN;
                end
                edit.drop_en[4]  = (item.key != 8'h00);
                edit.drop_key[4] = item.key;
                if (is_mod(item.key))
                begin
                    clr = clr | mod_bit(item.key);
                end
                st_next.mods      = st.mods & ~clr;
                st_next.enter_sub = 1'b0;
            end
            KIND_TICK:
            begin
                if (st.hold_timer != '0)
                begin
                    st_next.hold_timer = st.hold_timer - TIMER_W'(1);
                end
                if (st.tap_timer != '0)
                begin
                    st_next.tap_timer = st.tap_timer - TIMER_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

endmodule

>>> design/hid_keyboard_report_remapper_unit.sv
// Boot-keyboard report keeper with caps, arrow and muhenkan remapping. One request is taken
// per clock: it is captured in an input register, then evaluated against the held report in a
// single pass through the remap rules and the slot compaction network, and a press or
// release leaves its report in the output register, from which it is offered. Ticks only
// count the caps timers down, unused kinds change nothing, and neither produces a report.
// Input is only held back while a finished report waits to be taken and the next request
// would produce another. Configuration writes are registered.
module hid_keyboard_report_remapper_unit
    import hidkr_pkg::*;
#(
    parameter int KEY_SLOTS = DEFAULT_KEY_SLOTS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_req_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_report_t          out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_wdata
);

    cfg_t                      cfg_reg;
    logic                      in_valid_reg;
    in_req_t                   in_item_reg;
    ctl_state_t                st_reg;
    ctl_state_t                st_next;
    logic [KEY_SLOTS-1:0][7:0] slots_reg;
    logic [KEY_SLOTS-1:0][7:0] slots_next;
    edit_req_t                 edit;
    logic                      emit;
    logic                      advance;
    logic                      out_valid_reg;
    out_report_t               out_data_reg;
    out_report_t               report_next;
    logic [REPORT_SLOTS-1:0][7:0] rep_slots;

    hidkr_remap u_remap (
        .item    (in_item_reg),
        .st      (st_reg),
        .cfg     (cfg_reg),
        .st_next (st_next),
        .edit    (edit),
        .emit    (emit)
    );

    hidkr_slot_edit #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_slot_edit (
        .slots     (slots_reg),
        .edit      (edit),
        .slots_out (slots_next)
    );

    assign advance  = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    for (genvar j = 0; j < REPORT_SLOTS; j++)
    begin : g_rep
        if (j < KEY_SLOTS)
        begin : g_used
            assign rep_slots[j] = slots_next[j];
        end
        else
        begin : g_unused
            assign rep_slots[j] = 8'h00;
        end
    end

    always_comb
    begin
        report_next.out_modifiers = st_next.mods;
        report_next.slot_0        = rep_slots[0];
        report_next.slot_1        = rep_slots[1];
        report_next.slot_2        = rep_slots[2];
        report_next.slot_3        = rep_slots[3];
        report_next.slot_4        = rep_slots[4];
        report_next.slot_5        = rep_slots[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks   <= RST_HOLD_TICKS;
            cfg_reg.recent_limit <= RST_RECENT_LIMIT;
            cfg_reg.min_gap      <= RST_MIN_GAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOLD_TICKS:   cfg_reg.hold_ticks   <= cfg_wdata;
                CFG_RECENT_LIMIT: cfg_reg.recent_limit <= cfg_wdata;
                CFG_MIN_GAP:      cfg_reg.min_gap      <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            slots_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                st_reg    <= st_next;
                slots_reg <= slots_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_data_reg <= report_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // injected enter always sits at the front while active
    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.enter_sub |-> slots_reg[0] == USAGE_ENTER)
        else $error("enter substitute active without enter in front slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.caps_sub == 8'h00 || st_reg.caps_sub == USAGE_LGUI)
        else $error("unexpected caps substitute");

    // ticks leave the report untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.kind == KIND_TICK
        |=> $stable(slots_reg) && $stable(st_reg.mods) && $stable(st_reg.enter_sub))
        else $error("tick altered report state");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !emit && out_valid_reg && !out_ready |=> $stable(out_data_reg))
        else $error("silent request disturbed waiting report");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench
    import hidkr_pkg::*;
();

    localparam int NSLOT        = DEFAULT_KEY_SLOTS;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 60;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 125;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam logic [7:0] USAGE_NONE     = 8'h00;
    localparam logic [7:0] USAGE_LETTER_A = 8'h04;
    localparam logic [7:0] USAGE_MOD_END  = 8'hE8;

    typedef enum {ROW_REQ, ROW_CFG} row_op_t;
    typedef enum {CHK_MODEL, CHK_TYPED, CHK_SILENT} check_t;

    typedef struct {
        row_op_t     op;
        in_req_t     req;
        check_t      mode;
        out_report_t want;
        cfg_t        cfg;
    } script_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_req_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_report_t          out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HOLD_TICKS;
    logic [TIMER_W-1:0]   cfg_wdata = '0;

    // predicted keyboard state
    logic [7:0]         held_mods = 8'h00;
    logic [7:0]         held_slots [NSLOT];
    logic               caps_down = 1'b0;
    logic [TIMER_W-1:0] hold_cnt  = '0;
    logic [TIMER_W-1:0] tap_cnt   = '0;
    logic [7:0]         caps_swap = 8'h00;
    logic               enter_swap = 1'b0;
    cfg_t               live_cfg  = '{RST_HOLD_TICKS, RST_RECENT_LIMIT, RST_MIN_GAP};

    out_report_t pending_reports [$];
    script_row_t script [$];

    int failures        = 0;
    int items_sent      = 0;
    int reports_checked = 0;
    int cfg_loads       = 0;
    int idle_odds       = 20;
    bit calm            = 1'b0;
    bit held_off        = 1'b0;

    hid_keyboard_report_remapper_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        foreach (held_slots[i])
            held_slots[i] = USAGE_NONE;
    end

    function automatic bit is_modifier_usage(input logic [7:0] k);
        return k >= USAGE_MOD_BASE && k < USAGE_MOD_END;
    endfunction

    function automatic void drop_usage(input logic [7:0] k);
        if (k == USAGE_NONE)
            return;
        if (is_modifier_usage(k))
            held_mods &= ~(8'h01 << k[2:0]);
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (held_slots[i] == k)
            begin
                for (int j = i; j < NSLOT - 1; j++)
                    held_slots[j] = held_slots[j + 1];
                held_slots[NSLOT - 1] = USAGE_NONE;
            end
        end
    endfunction

    function automatic void bring_front(input logic [7:0] k);
        drop_usage(k);
        for (int j = NSLOT - 1; j > 0; j--)
            held_slots[j] = held_slots[j - 1];
        held_slots[0] = k;
    endfunction

    function automatic bit next_report(input in_req_t req, output out_report_t rep);
        logic [7:0]         k;
        logic [TIMER_W-1:0] t;
        rep = '0;
        k = req.key;
        case (req.kind)
            KIND_TICK:
            begin
                if (hold_cnt != 0)
                    hold_cnt--;
                if (tap_cnt != 0)
                    tap_cnt--;
                return 1'b0;
            end
            KIND_PRESS:
            begin
                if (k == USAGE_CAPS && (held_mods & SHIFT_MASK) == 8'h00)
                begin
                    // second tap inside the window turns into left gui
                    if (tap_cnt != 0)
                    begin
                        drop_usage(k);
                        k = USAGE_LGUI;
                        caps_swap = k;
                    end
                    if (!caps_down && hold_cnt < live_cfg.recent_limit)
                    begin
                        t = hold_cnt;
                        if (t != 0 && t < live_cfg.min_gap)
                            t = live_cfg.min_gap;
                        tap_cnt = t;
                    end
                    hold_cnt = live_cfg.hold_ticks;
                end
                else
                begin
                    hold_cnt = '0;
                    tap_cnt = '0;
                end
                if (k == USAGE_CAPS)
                    caps_down = 1'b1;
                else if (caps_down && k == USAGE_DOWN)
                    k = USAGE_APP;
                if (is_modifier_usage(k))
                    held_mods |= 8'h01 << k[2:0];
                else if (k == USAGE_MUHENKAN && held_mods == 8'h00)
                begin
                    enter_swap = 1'b1;
                    bring_front(USAGE_ENTER);
                end
                else
                begin
                    if (enter_swap)
                    begin
                        drop_usage(USAGE_ENTER);
                        drop_usage(USAGE_MUHENKAN);
                        enter_swap = 1'b0;
                    end
                    if (k != USAGE_NONE)
                        bring_front(k);
                end
            end
            KIND_RELEASE:
            begin
                if (k == USAGE_CAPS)
                begin
                    caps_down = 1'b0;
                    drop_usage(caps_swap);
                    caps_swap = USAGE_NONE;
                end
                if (k == USAGE_CAPS || k == USAGE_DOWN)
                    drop_usage(USAGE_APP);
                if (enter_swap)
                begin
                    drop_usage(USAGE_ENTER);
                    drop_usage(USAGE_MUHENKAN);
                end
                drop_usage(k);
                enter_swap = 1'b0;
            end
            default:
                return 1'b0;
        endcase
        rep.out_modifiers = held_mods;
        rep.slot_0 = held_slots[0];
        rep.slot_1 = held_slots[1];
        rep.slot_2 = held_slots[2];
        rep.slot_3 = held_slots[3];
        rep.slot_4 = held_slots[4];
        rep.slot_5 = held_slots[5];
        return 1'b1;
    endfunction

    function automatic out_report_t report_of(input logic [7:0] m, input logic [7:0] s0,
                                              input logic [7:0] s1, input logic [7:0] s2);
        out_report_t r;
        r = '0;
        r.out_modifiers = m;
        r.slot_0 = s0;
        r.slot_1 = s1;
        r.slot_2 = s2;
        return r;
    endfunction

    function automatic void add_req(input logic [1:0] kind, input logic [7:0] key,
                                    input check_t mode, input out_report_t want);
        script_row_t row;
        row.op = ROW_REQ;
        row.req.kind = kind;
        row.req.key = key;
        row.mode = mode;
        row.want = want;
        row.cfg = '0;
        script.push_back(row);
    endfunction

    function automatic void add_cfg(input cfg_t c);
        script_row_t row;
        row.op = ROW_CFG;
        row.req = '0;
        row.mode = CHK_SILENT;
        row.want = '0;
        row.cfg = c;
        script.push_back(row);
    endfunction

    function automatic logic [7:0] pool_key();
        case ($urandom_range(0, 6))
            0, 1:
                return USAGE_LETTER_A + 8'($urandom_range(0, 7));
            2:
                return USAGE_MOD_BASE + 8'($urandom_range(0, 7));
            3:
                return USAGE_DOWN;
            4:
                return USAGE_MUHENKAN;
            5:
                return USAGE_CAPS;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return USAGE_ENTER;
                    1:       return USAGE_APP;
                    2:       return USAGE_LGUI;
                    default: return USAGE_NONE;
                endcase
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    task automatic offer(input in_req_t req, input check_t mode, input out_report_t want);
        out_report_t predicted;
        bit          has_report;
        if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (!in_ready);
        has_report = next_report(req, predicted);
        if (req.kind != KIND_UNUSED)
            items_sent++;
        if (mode == CHK_TYPED)
            pending_reports.push_back(want);
        else if (mode == CHK_MODEL && has_report)
            pending_reports.push_back(predicted);
    endtask

    task automatic send(input logic [1:0] kind, input logic [7:0] key);
        in_req_t req;
        req.kind = kind;
        req.key = key;
        offer(req, CHK_MODEL, '0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_cfg(input cfg_t c);
        cfg_we <= 1'b1;
        cfg_index <= CFG_HOLD_TICKS;
        cfg_wdata <= c.hold_ticks;
        @(posedge clk);
        cfg_index <= CFG_RECENT_LIMIT;
        cfg_wdata <= c.recent_limit;
        @(posedge clk);
        cfg_index <= CFG_MIN_GAP;
        cfg_wdata <= c.min_gap;
        @(posedge clk);
        cfg_we <= 1'b0;
        live_cfg = c;
        cfg_loads++;
    endtask

    // tap, release, wait, tap again and again so the double tap window gets exercised
    task automatic caps_burst();
        send(KIND_PRESS, USAGE_CAPS);
        if ($urandom_range(0, 2) == 0)
        begin
            send(KIND_PRESS, USAGE_DOWN);
            send(KIND_RELEASE, USAGE_DOWN);
        end
        send(KIND_RELEASE, USAGE_CAPS);
        repeat ($urandom_range(0, 14)) send(KIND_TICK, 8'($urandom));
        send(KIND_PRESS, USAGE_CAPS);
        send(KIND_RELEASE, USAGE_CAPS);
        repeat ($urandom_range(0, 3)) send(KIND_TICK, 8'($urandom));
        send(KIND_PRESS, USAGE_CAPS);
        if ($urandom_range(0, 1) == 0)
            send(KIND_PRESS, pool_key());
        send(KIND_RELEASE, USAGE_CAPS);
    endtask

    task automatic random_event();
        int         pick;
        logic [7:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            caps_burst();
        else if (pick < 40)
            send(KIND_PRESS, pool_key());
        else if (pick < 65)
        begin
            k = held_slots[$urandom_range(0, NSLOT - 1)];
            if (k == USAGE_NONE || $urandom_range(0, 3) == 0)
                k = pool_key();
            send(KIND_RELEASE, k);
        end
        else if (pick < 78)
            send(KIND_TICK, 8'($urandom));
        else if (pick < 93)
            send(2'($urandom_range(0, 1)), 8'($urandom));
        else
            send(2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    // report checker
    always @(posedge clk)
    begin
        out_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report %h arrived with no request behind it", out_data);
                failures++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("out_modifiers", want.out_modifiers, out_data.out_modifiers);
                check_field("slot_0", want.slot_0, out_data.slot_0);
                check_field("slot_1", want.slot_1, out_data.slot_1);
                check_field("slot_2", want.slot_2, out_data.slot_2);
                check_field("slot_3", want.slot_3, out_data.slot_3);
                check_field("slot_4", want.slot_4, out_data.slot_4);
                check_field("slot_5", want.slot_5, out_data.slot_5);
                reports_checked++;
            end
        end
    end

    // report sink with random stalls and one long hold-off
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && !held_off && reports_checked >= 120)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && idle_odds != 0 && $urandom_range(1, 100) <= idle_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        cfg_t phase_cfg [PHASES];
        int   phase_odds [PHASES];
        int   target;

        phase_cfg[0] = '{10'd12, 10'd10, 10'd4};
        phase_cfg[1] = '{10'd0, 10'd0, 10'd0};
        phase_cfg[2] = '{10'd1023, 10'd1023, 10'd1023};
        phase_cfg[3] = '{10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                         10'($urandom_range(0, 40))};
        phase_cfg[4] = '{RST_HOLD_TICKS, RST_RECENT_LIMIT, RST_MIN_GAP};
        phase_odds[0] = 25;
        phase_odds[1] = 40;
        phase_odds[2] = 10;
        phase_odds[3] = 30;
        phase_odds[4] = 0;

        // extremes of the key field and modifier edges, readable straight off
        add_req(KIND_PRESS, USAGE_LETTER_A, CHK_TYPED,
                report_of(8'h00, USAGE_LETTER_A, USAGE_NONE, USAGE_NONE));
        add_req(KIND_PRESS, USAGE_NONE, CHK_TYPED,
                report_of(8'h00, USAGE_LETTER_A, USAGE_NONE, USAGE_NONE));
        add_req(KIND_PRESS, 8'hFF, CHK_TYPED,
                report_of(8'h00, 8'hFF, USAGE_LETTER_A, USAGE_NONE));
        add_req(KIND_PRESS, 8'hE0, CHK_TYPED,
                report_of(8'h01, 8'hFF, USAGE_LETTER_A, USAGE_NONE));
        add_req(KIND_PRESS, 8'hE7, CHK_TYPED,
                report_of(8'h81, 8'hFF, USAGE_LETTER_A, USAGE_NONE));
        add_req(KIND_RELEASE, 8'hE0, CHK_TYPED,
                report_of(8'h80, 8'hFF, USAGE_LETTER_A, USAGE_NONE));
        add_req(KIND_RELEASE, USAGE_NONE, CHK_TYPED,
                report_of(8'h80, 8'hFF, USAGE_LETTER_A, USAGE_NONE));
        add_req(KIND_UNUSED, 8'hAA, CHK_SILENT, '0);
        add_req(KIND_TICK, 8'h55, CHK_SILENT, '0);
        add_req(KIND_RELEASE, 8'hE7, CHK_TYPED,
                report_of(8'h00, 8'hFF, USAGE_LETTER_A, USAGE_NONE));
        // fill all slots and push one more
        add_req(KIND_PRESS, 8'h05, CHK_MODEL, '0);
        add_req(KIND_PRESS, 8'h06, CHK_MODEL, '0);
        add_req(KIND_PRESS, 8'h07, CHK_MODEL, '0);
        add_req(KIND_PRESS, 8'h08, CHK_MODEL, '0);
        add_req(KIND_PRESS, 8'h09, CHK_MODEL, '0);
        // muhenkan to enter, then cleared by the next key
        add_req(KIND_PRESS, USAGE_MUHENKAN, CHK_MODEL, '0);
        add_req(KIND_PRESS, USAGE_LETTER_A, CHK_MODEL, '0);
        // caps held with down arrow
        add_req(KIND_PRESS, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_PRESS, USAGE_DOWN, CHK_MODEL, '0);
        add_req(KIND_RELEASE, USAGE_DOWN, CHK_MODEL, '0);
        add_req(KIND_RELEASE, USAGE_CAPS, CHK_MODEL, '0);
        // short timers for a double tap
        add_cfg('{10'd3, 10'd1023, 10'd1023});
        add_req(KIND_PRESS, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_RELEASE, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_TICK, 8'h00, CHK_SILENT, '0);
        add_req(KIND_PRESS, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_RELEASE, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_PRESS, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_RELEASE, USAGE_CAPS, CHK_MODEL, '0);
        // caps under shift is an ordinary key
        add_req(KIND_PRESS, 8'hE1, CHK_MODEL, '0);
        add_req(KIND_PRESS, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_RELEASE, USAGE_CAPS, CHK_MODEL, '0);
        add_req(KIND_RELEASE, 8'hE1, CHK_MODEL, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].op == ROW_CFG)
            begin
                settle();
                load_cfg(script[i].cfg);
            end
            else
                offer(script[i].req, script[i].mode, script[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            load_cfg(phase_cfg[p]);
            idle_odds = phase_odds[p];
            calm = (p == PHASES - 1);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_event();
        end
        settle();

        $display("covered %0d requests incl. ticks over %0d register settings",
                 items_sent, cfg_loads);
        $display("%0d reports compared, caps/arrow/muhenkan remaps and slot overflow driven",
                 reports_checked);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
